// ===== rtl/core/hftc_pkg.sv =====
// Package for the hashed FIFO tag cache: word types, mode codes, sequencer states
// and default sizes. Used by hftc_hash and hashed_fifo_tag_cache.
package hftc_pkg;

  localparam int unsigned CACHE_ENTRIES_DEF = 128;
  localparam int unsigned HASH_BITS_DEF     = 8;
  localparam logic [63:0] GOLDEN_MUL        = 64'h9e3779b97f4a7c16;
  localparam int unsigned ADDR_SHIFT        = 4;
  localparam int unsigned SLOT_W            = 7;

  typedef enum logic [1:0] {
    MODE_LOOKUP   = 2'd0,
    MODE_ALLOCATE = 2'd1,
    MODE_FINALIZE = 2'd2,
    MODE_FLUSH    = 2'd3
  } mode_e_t;

  typedef struct packed {
    mode_e_t             mode;
    logic [63:0]         key_address;
    logic [63:0]         pred_bits;
    logic [63:0]         match_mask;
    logic [63:0]         match_value;
    logic [SLOT_W-1:0]   hint_slot;
    logic [SLOT_W-1:0]   prev_slot;
    logic [SLOT_W-1:0]   target_slot;
  } req_word_t;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic [SLOT_W-1:0] next_hint;
  } rsp_word_t;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_LHCHK,
    S_LHWAIT,
    S_LHEAD,
    S_LWALK,
    S_LCMP,
    S_A1,
    S_AUWAIT,
    S_AUHEAD,
    S_AUWALK,
    S_AURD,
    S_AKEY,
    S_AKWAIT,
    S_AKHEAD,
    S_FLUSH,
    S_DONE
  } state_t;

endpackage

// ===== rtl/core/hashed_fifo_tag_cache.sv =====
// Hashed FIFO tag cache: top level with the slot memories and the sequencer.
// Depends on hftc_pkg and hftc_hash.
//
// Usage: one request word on req (valid/ready) gives one response word on rsp.
// Lookup tries the hint slot, then walks the key's chain one slot at a time;
// allocate takes the FIFO head, unlinks it from its old chain when its
// address is not zero and links it at the head of the key's chain; finalize
// stores mask and value; flush zeroes every address. Each memory has one write
// and one registered read port, and every chain step is a read of chain_mem.
// The block takes one request at a time; req_ready is high only while idle.
// After reset a clearing pass initializes every memory but mask and value,
// with req_ready low.
// The response sits in an output register; while rsp is stalled the block
// still accepts and works on the next request, and holds its result until
// the register frees.
module hashed_fifo_tag_cache #(
  parameter int unsigned CACHE_ENTRIES = hftc_pkg::CACHE_ENTRIES_DEF,
  parameter int unsigned HASH_BITS     = hftc_pkg::HASH_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  hftc_pkg::req_word_t req,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output hftc_pkg::rsp_word_t rsp
);
  import hftc_pkg::*;

  localparam int unsigned SW    = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
  localparam int unsigned LW    = SW + 1;
  localparam int unsigned HS    = 1 << HASH_BITS;
  localparam int unsigned MAXD  = (CACHE_ENTRIES > HS) ? CACHE_ENTRIES : HS;
  localparam int unsigned CNTW  = $clog2(MAXD);
  localparam logic [LW-1:0] LINK_NONE = '1;

  // Memories.
  logic [63:0]     tag_mem   [CACHE_ENTRIES];
  logic [63:0]     mask_mem  [CACHE_ENTRIES];
  logic [63:0]     val_mem   [CACHE_ENTRIES];
  logic [SW-1:0]   hint_mem  [CACHE_ENTRIES];
  logic [LW-1:0]   chain_mem [CACHE_ENTRIES];
  logic [SW-1:0]   fifo_mem  [CACHE_ENTRIES];
  logic [LW-1:0]   head_mem  [HS];

  logic [SW-1:0]   rd_slot;
  logic [63:0]     rd_tag, rd_mask, rd_val;
  logic [SW-1:0]   rd_hint, rd_fifo;
  logic [LW-1:0]   rd_chain, rd_head;

  logic            tag_we, pv_we, hint_we, chain_we, fifo_we, head_we;
  logic [SW-1:0]   tag_wa, pv_wa, hint_wa, chain_wa, fifo_wa;
  logic [HASH_BITS-1:0] head_wa;
  logic [63:0]     tag_wd;
  logic [SW-1:0]   hint_wd, fifo_wd;
  logic [LW-1:0]   chain_wd, head_wd;

  // Control and datapath registers.
  state_t          state, state_next;
  req_word_t       cur_req;
  logic [LW-1:0]   cur;
  logic [LW-1:0]   prev;
  logic [SW:0]     steps;
  logic [SW-1:0]   victim;
  logic [SW-1:0]   fifo_head, fifo_tail;
  logic [CNTW-1:0] cnt;
  rsp_word_t       res;

  logic            hash_start, hash_done;
  logic [63:0]     hash_addr;
  logic [HASH_BITS-1:0] hash_bkt;

  logic            accept;
  logic            load_out;
  logic            slot_match;
  logic            chain_end;
  logic            hint_oor, prev_oor, req_tgt_oor;
  logic            cur_is_victim;
  logic [SW-1:0]   lookup_nh;

  hftc_hash #(.HASH_BITS(HASH_BITS)) u_hash (
    .clk    (clk),
    .rst    (rst),
    .start  (hash_start),
    .addr   (hash_addr),
    .done   (hash_done),
    .bucket (hash_bkt)
  );

  assign accept   = req_valid && req_ready;
  assign load_out = !rsp_valid || rsp_ready;

  assign hint_oor    = 32'(cur_req.hint_slot) >= CACHE_ENTRIES;
  assign prev_oor    = 32'(cur_req.prev_slot) >= CACHE_ENTRIES;
  assign req_tgt_oor = 32'(req.target_slot) >= CACHE_ENTRIES;
  assign slot_match  = (rd_tag == cur_req.key_address) &&
                       (((cur_req.pred_bits ^ rd_val) & rd_mask) == 64'd0);
  assign chain_end   = (32'(cur) >= CACHE_ENTRIES) || (32'(steps) == CACHE_ENTRIES);
  assign cur_is_victim = cur[SW-1:0] == victim;
  // The hint write to prev_slot is forwarded to next_hint when prev_slot is the found slot.
  assign lookup_nh   = (!prev_oor && SW'(cur_req.prev_slot) == cur[SW-1:0]) ?
                       cur[SW-1:0] : rd_hint;

  // Memory ports.
  always_ff @(posedge clk) begin
    if (tag_we) tag_mem[tag_wa] <= tag_wd;
    rd_tag <= tag_mem[rd_slot];
  end
  always_ff @(posedge clk) begin
    if (pv_we) begin
      mask_mem[pv_wa] <= req.match_mask;
      val_mem[pv_wa]  <= req.match_value;
    end
    rd_mask <= mask_mem[rd_slot];
    rd_val  <= val_mem[rd_slot];
  end
  always_ff @(posedge clk) begin
    if (hint_we) hint_mem[hint_wa] <= hint_wd;
    rd_hint <= hint_mem[rd_slot];
  end
  always_ff @(posedge clk) begin
    if (chain_we) chain_mem[chain_wa] <= chain_wd;
    rd_chain <= chain_mem[rd_slot];
  end
  always_ff @(posedge clk) begin
    if (fifo_we) fifo_mem[fifo_wa] <= fifo_wd;
    rd_fifo <= fifo_mem[rd_slot];
  end
  always_ff @(posedge clk) begin
    if (head_we) head_mem[head_wa] <= head_wd;
    rd_head <= head_mem[hash_bkt];
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR:  if (32'(cnt) == MAXD - 1) state_next = S_IDLE;
      S_IDLE: begin
        if (accept) begin
          unique case (req.mode)
            MODE_LOOKUP:   state_next = S_LHCHK;
            MODE_ALLOCATE: state_next = S_A1;
            MODE_FINALIZE: state_next = S_DONE;
            MODE_FLUSH:    state_next = S_FLUSH;
            default:       state_next = S_IDLE;
          endcase
        end
      end
      S_LHCHK:  state_next = (!hint_oor && slot_match) ? S_DONE : S_LHWAIT;
      S_LHWAIT: if (hash_done) state_next = S_LHEAD;
      S_LHEAD:  state_next = S_LWALK;
      S_LWALK:  state_next = chain_end ? S_DONE : S_LCMP;
      S_LCMP:   state_next = slot_match ? S_DONE : S_LWALK;
      S_A1:     state_next = (rd_tag != 64'd0) ? S_AUWAIT : S_AKEY;
      S_AUWAIT: if (hash_done) state_next = S_AUHEAD;
      S_AUHEAD: state_next = S_AUWALK;
      S_AUWALK: state_next = chain_end ? S_AKEY : S_AURD;
      S_AURD:   state_next = cur_is_victim ? S_AKEY : S_AUWALK;
      S_AKEY:   state_next = S_AKWAIT;
      S_AKWAIT: if (hash_done) state_next = S_AKHEAD;
      S_AKHEAD: state_next = S_DONE;
      S_FLUSH:  if (32'(cnt) == CACHE_ENTRIES - 1) state_next = S_DONE;
      S_DONE:   if (load_out) state_next = S_IDLE;
      default:  state_next = S_CLEAR;
    endcase
  end

  // Outputs: handshake, memory controls and hash requests.
  always_comb begin
    req_ready  = 1'b0;
    rd_slot    = cur[SW-1:0];
    hash_start = 1'b0;
    hash_addr  = cur_req.key_address;
    tag_we = 1'b0;   tag_wa = victim;   tag_wd = cur_req.key_address;
    pv_we = 1'b0;    pv_wa = SW'(req.target_slot);
    hint_we = 1'b0;  hint_wa = victim;  hint_wd = '0;
    chain_we = 1'b0; chain_wa = victim; chain_wd = rd_head;
    fifo_we = 1'b0;  fifo_wa = fifo_tail; fifo_wd = fifo_head;
    head_we = 1'b0;  head_wa = hash_bkt; head_wd = LW'(victim);
    unique case (state)
      S_CLEAR: begin
        tag_wa   = cnt[SW-1:0];
        hint_wa  = cnt[SW-1:0];
        chain_wa = cnt[SW-1:0];
        fifo_wa  = cnt[SW-1:0];
        head_wa  = cnt[HASH_BITS-1:0];
        tag_wd   = '0;
        chain_wd = LINK_NONE;
        head_wd  = LINK_NONE;
        fifo_wd  = (cnt == '0) ? SW'(CACHE_ENTRIES - 1) : SW'(cnt - 1'b1);
        tag_we   = 32'(cnt) < CACHE_ENTRIES;
        hint_we  = tag_we;
        chain_we = tag_we;
        fifo_we  = tag_we;
        head_we  = 32'(cnt) < HS;
      end
      S_IDLE: begin
        req_ready = 1'b1;
        hash_addr = req.key_address;
        rd_slot   = (req.mode == MODE_ALLOCATE) ? fifo_head : SW'(req.hint_slot);
        hash_start = accept && (req.mode == MODE_LOOKUP);
        pv_we      = accept && (req.mode == MODE_FINALIZE) && !req_tgt_oor;
      end
      S_LCMP: begin
        hint_we = slot_match && !prev_oor;
        hint_wa = SW'(cur_req.prev_slot);
        hint_wd = cur[SW-1:0];
      end
      S_A1: begin
        fifo_we    = 1'b1;
        hash_addr  = rd_tag;
        hash_start = rd_tag != 64'd0;
      end
      S_AURD: begin
        chain_wd = rd_chain;
        head_wd  = rd_chain;
        chain_wa = prev[SW-1:0];
        if (cur_is_victim) begin
          if (prev == LINK_NONE) head_we = 1'b1;
          else chain_we = 1'b1;
        end
      end
      S_AKEY: hash_start = 1'b1;
      S_AKHEAD: begin
        chain_we = 1'b1;
        head_we  = 1'b1;
        tag_we   = 1'b1;
        hint_we  = 1'b1;
      end
      S_FLUSH: begin
        tag_we = 1'b1;
        tag_wa = cnt[SW-1:0];
        tag_wd = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      cnt       <= '0;
      fifo_head <= SW'(CACHE_ENTRIES - 1);
      fifo_tail <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR || state == S_FLUSH) begin
        cnt <= (state_next != state) ? '0 : cnt + 1'b1;
      end
      if (state == S_A1) begin
        fifo_head <= rd_fifo;
        fifo_tail <= fifo_head;
      end
      if (state == S_DONE && load_out) rsp_valid <= 1'b1;
      else if (rsp_ready) rsp_valid <= 1'b0;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (state == S_DONE && load_out) rsp <= res;
    case (state)
      S_IDLE: begin
        cur_req <= req;
        res     <= '0;
      end
      S_LHCHK: begin
        if (!hint_oor && slot_match) begin
          res.hit       <= 1'b1;
          res.slot      <= SLOT_W'(cur_req.hint_slot);
          res.next_hint <= SLOT_W'(rd_hint);
        end
      end
      S_LHEAD, S_AUHEAD: begin
        cur   <= rd_head;
        prev  <= LINK_NONE;
        steps <= '0;
      end
      S_LCMP: begin
        if (slot_match) begin
          res.hit       <= 1'b1;
          res.slot      <= SLOT_W'(cur[SW-1:0]);
          res.next_hint <= SLOT_W'(lookup_nh);
        end else begin
          cur   <= rd_chain;
          steps <= steps + 1'b1;
        end
      end
      S_A1: victim <= fifo_head;
      S_AURD: begin
        prev  <= cur;
        cur   <= rd_chain;
        steps <= steps + 1'b1;
      end
      S_AKHEAD: begin
        res.hit       <= 1'b1;
        res.slot      <= SLOT_W'(victim);
        res.next_hint <= '0;
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/core/hftc_hash.sv =====
// Multi-cycle golden-ratio hash: bucket = top HASH_BITS of (addr >> 4) * GOLDEN_MUL.
// Depends on hftc_pkg. The 64-bit product is built from four 16-bit partial products.
module hftc_hash #(
  parameter int unsigned HASH_BITS = hftc_pkg::HASH_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [63:0]          addr,
  output logic                 done,
  output logic [HASH_BITS-1:0] bucket
);
  import hftc_pkg::*;

  logic [63:0] operand;
  logic [63:0] prod;
  logic [63:0] acc;
  logic [2:0]  step;
  logic        busy;
  logic [79:0] part;

  assign part   = operand[{step[1:0], 4'b0} +: 16] * GOLDEN_MUL;
  assign bucket = acc[63 -: HASH_BITS];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      step <= '0;
    end else if (busy) begin
      step <= step + 3'd1;
      if (step == 3'd4) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // One partial product per cycle, registered, then folded into the sum.
  always_ff @(posedge clk) begin
    if (start) begin
      operand <= addr >> ADDR_SHIFT;
      acc     <= '0;
    end else if (busy) begin
      if (step != 3'd4) begin
        prod <= part[63:0] << {step[1:0], 4'b0};
      end
      if (step != 3'd0) begin
        acc <= acc + prod;
      end
    end
  end

endmodule

// ===== tb/sv/hashed_fifo_tag_cache_tb.sv =====
// Testbench for hashed_fifo_tag_cache: directed and random lookup, allocate,
// finalize and flush words checked against an in-bench model of the cache.
// Depends on hftc_pkg and the RTL of the block.
module hashed_fifo_tag_cache_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import hftc_pkg::*;

  localparam int unsigned NSLOT = CACHE_ENTRIES_DEF;
  localparam int unsigned NBKT  = 1 << HASH_BITS_DEF;
  localparam int unsigned NONE  = 16'hFFFF;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      req_valid = 1'b0;
  logic      req_ready;
  req_word_t req = '0;
  logic      rsp_valid;
  logic      rsp_ready = 1'b0;
  rsp_word_t rsp;

  hashed_fifo_tag_cache u_top (
    .clk(clk), .rst(rst), .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
  );

  always #5 clk = ~clk;

  // Shadow copy of the cache state.
  logic [63:0] m_addr [NSLOT];
  logic [63:0] m_mask [NSLOT];
  logic [63:0] m_val  [NSLOT];
  bit          m_fin  [NSLOT];
  int unsigned m_hint [NSLOT];
  int unsigned m_chain[NSLOT];
  int unsigned m_fnext[NSLOT];
  int unsigned m_bhead[NBKT];
  int unsigned m_fhead, m_ftail;

  rsp_word_t   expected_rsp_q[$];
  logic [63:0] used_keys[$];
  int          err_count = 0;
  bit          stall_en = 1'b1;

  function automatic int unsigned bucket_of(logic [63:0] a);
    logic [63:0] p;
    p = (a >> ADDR_SHIFT) * GOLDEN_MUL;
    return 32'(p >> (64 - HASH_BITS_DEF));
  endfunction

  function automatic bit slot_hit(int unsigned s, logic [63:0] k, logic [63:0] pb);
    return m_addr[s] == k && ((pb ^ m_val[s]) & m_mask[s]) == 64'd0;
  endfunction

  function automatic void cache_reset();
    for (int i = 0; i < NSLOT; i++) begin
      m_addr[i] = '0; m_mask[i] = '0; m_val[i] = '0; m_fin[i] = 1'b0;
      m_hint[i] = 0; m_chain[i] = NONE; m_fnext[i] = (i == 0) ? NSLOT - 1 : i - 1;
    end
    for (int i = 0; i < NBKT; i++) m_bhead[i] = NONE;
    m_fhead = NSLOT - 1;
    m_ftail = 0;
  endfunction

  function automatic void chain_unlink(int unsigned s, int unsigned b);
    int unsigned cur, prv, steps;
    cur = m_bhead[b]; prv = NONE; steps = 0;
    while (cur < NSLOT && steps < NSLOT) begin
      if (cur == s) begin
        if (prv < NSLOT) m_chain[prv] = m_chain[cur];
        else m_bhead[b] = m_chain[cur];
        return;
      end
      prv = cur; cur = m_chain[cur]; steps++;
    end
  endfunction

  function automatic rsp_word_t cache_step(req_word_t w);
    rsp_word_t r;
    int unsigned found, cur, steps, s, b;
    r = '0;
    case (w.mode)
      MODE_LOOKUP: begin
        found = NONE;
        if (slot_hit(w.hint_slot, w.key_address, w.pred_bits)) begin
          found = w.hint_slot;
        end else begin
          cur = m_bhead[bucket_of(w.key_address)]; steps = 0;
          while (cur < NSLOT && steps < NSLOT) begin
            if (slot_hit(cur, w.key_address, w.pred_bits)) begin
              found = cur;
              m_hint[w.prev_slot] = cur;
              break;
            end
            cur = m_chain[cur]; steps++;
          end
        end
        if (found < NSLOT) begin
          r.hit = 1'b1; r.slot = SLOT_W'(found); r.next_hint = SLOT_W'(m_hint[found]);
        end
      end
      MODE_ALLOCATE: begin
        s = m_fhead;
        m_fhead = m_fnext[s];
        m_fnext[m_ftail] = s;
        m_ftail = s;
        if (m_addr[s] != 0) chain_unlink(s, bucket_of(m_addr[s]));
        b = bucket_of(w.key_address);
        m_chain[s] = m_bhead[b];
        m_bhead[b] = s;
        m_addr[s] = w.key_address;
        m_hint[s] = 0;
        r.hit = 1'b1; r.slot = SLOT_W'(s);
      end
      MODE_FINALIZE: begin
        m_mask[w.target_slot] = w.match_mask;
        m_val[w.target_slot] = w.match_value;
        m_fin[w.target_slot] = 1'b1;
      end
      default: begin
        for (int i = 0; i < NSLOT; i++) m_addr[i] = '0;
      end
    endcase
    return r;
  endfunction

  // A lookup may compare any slot whose address equals the key; those must have
  // been finalized so that no never-written mask is read.
  function automatic bit lookup_safe(logic [63:0] k);
    for (int i = 0; i < NSLOT; i++)
      if (m_addr[i] == k && !m_fin[i]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic int unsigned gap_len();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned exp);
    $display("mismatch in %s: got %0d, expected %0d", what, got, exp);
    err_count++;
  endtask

  // The block is never ready in the cycle after it accepts a word, so the wait
  // for a negedge before valid rises again costs no throughput.
  task automatic send_word(req_word_t w);
    int unsigned g;
    if (w.mode == MODE_LOOKUP && !lookup_safe(w.key_address)) w.mode = MODE_FINALIZE;
    g = stall_en ? gap_len() : 0;
    repeat (g + 1) @(negedge clk);
    req <= w;
    req_valid <= 1'b1;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    expected_rsp_q.push_back(cache_step(w));
    @(negedge clk);
    req_valid <= 1'b0;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [63:0] pick_key();
    if (used_keys.size() != 0 && $urandom_range(0, 9) < 8)
      return used_keys[$urandom_range(0, used_keys.size() - 1)];
    return rand64();
  endfunction

  task automatic send_op(mode_e_t m, logic [63:0] k, logic [63:0] pb, logic [63:0] mk,
                         logic [63:0] mv, int unsigned hs, int unsigned ps, int unsigned ts);
    req_word_t w;
    w.mode = m; w.key_address = k; w.pred_bits = pb; w.match_mask = mk;
    w.match_value = mv; w.hint_slot = SLOT_W'(hs); w.prev_slot = SLOT_W'(ps);
    w.target_slot = SLOT_W'(ts);
    send_word(w);
  endtask

  // Allocate a key and finalize the slot it lands in.
  task automatic alloc_fin(logic [63:0] k, logic [63:0] mk, logic [63:0] mv);
    int unsigned s;
    s = m_fhead;
    send_op(MODE_ALLOCATE, k, rand64(), rand64(), rand64(), $urandom_range(0, 127),
            $urandom_range(0, 127), $urandom_range(0, 127));
    send_op(MODE_FINALIZE, rand64(), rand64(), mk, mv, $urandom_range(0, 127),
            $urandom_range(0, 127), s);
    used_keys.push_back(k);
  endtask

  // Response checker; the receiver stalls at random while stall_en is set.
  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) begin
      if (expected_rsp_q.size() == 0) begin
        report_mismatch("unexpected response count", 1, 0);
      end else begin
        rsp_word_t e;
        e = expected_rsp_q.pop_front();
        if (rsp.hit !== e.hit) report_mismatch("hit", rsp.hit, e.hit);
        if (rsp.slot !== e.slot) report_mismatch("slot", rsp.slot, e.slot);
        if (rsp.next_hint !== e.next_hint) report_mismatch("next_hint", rsp.next_hint,
                                                           e.next_hint);
      end
    end
  end

  always @(negedge clk) begin
    if (!stall_en) rsp_ready <= 1'b1;
    else rsp_ready <= (gap_len() == 0);
  end

  task automatic test_directed();
    alloc_fin(64'd0, 64'd0, 64'd0);
    alloc_fin(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    alloc_fin(64'h10, 64'h0F, 64'h05);
    // Same bucket as 0x10 differs only in the low nibble: chain of two.
    alloc_fin(64'h13, 64'd0, 64'd0);
    send_op(MODE_LOOKUP, 64'h10, 64'h05, 0, 0, 127, 0, 0);
    send_op(MODE_LOOKUP, 64'h10, 64'h04, 0, 0, 0, 5, 0);
    send_op(MODE_LOOKUP, 64'h13, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 0, 127, 0);
    send_op(MODE_LOOKUP, 64'h13, 0, 0, 0, 124, 0, 0);
    send_op(MODE_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 126, 3, 0);
    send_op(MODE_LOOKUP, 64'h1234, 0, 0, 0, 0, 0, 0);
    send_op(MODE_LOOKUP, 64'd0, 0, 0, 0, 127, 1, 0);
    send_op(MODE_FLUSH, 0, 0, 0, 0, 0, 0, 0);
    // After a flush the chains are stale; an allocate into a zeroed slot keeps them so.
    send_op(MODE_LOOKUP, 64'h10, 64'h05, 0, 0, 124, 2, 0);
    alloc_fin(64'h13, 64'd0, 64'd0);
    send_op(MODE_LOOKUP, 64'h13, 0, 0, 0, 0, 9, 0);
  endtask

  task automatic test_random(int n);
    int unsigned p;
    repeat (n) begin
      p = $urandom_range(0, 99);
      if (p < 30) begin
        alloc_fin(($urandom_range(0, 3) == 0) ? rand64() & 64'hFF : pick_key(),
                  ($urandom_range(0, 1)) ? rand64() & rand64() : 64'd0, rand64());
      end else if (p < 90) begin
        send_op(MODE_LOOKUP, pick_key(), rand64(), rand64(), rand64(),
                $urandom_range(0, 127), $urandom_range(0, 127), $urandom_range(0, 127));
      end else if (p < 97) begin
        send_op(MODE_FINALIZE, rand64(), rand64(), rand64(), rand64(),
                $urandom_range(0, 127), $urandom_range(0, 127), $urandom_range(0, 127));
      end else begin
        send_op(MODE_FLUSH, rand64(), rand64(), rand64(), rand64(),
                $urandom_range(0, 127), $urandom_range(0, 127), $urandom_range(0, 127));
      end
    end
  endtask

  initial begin
    cache_reset();
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    test_directed();
    stall_en = 1'b0;
    test_random(200);
    stall_en = 1'b1;
    test_random(1260);
    while (expected_rsp_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (err_count == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #20ms;
    $display("FAILED: results differ");
    $finish;
  end
endmodule

// ===== files.f =====
rtl/core/hftc_pkg.sv
rtl/core/hftc_hash.sv
rtl/core/hashed_fifo_tag_cache.sv
tb/sv/hashed_fifo_tag_cache_tb.sv
